// File: rtl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ssa_pkg.sv
// Types and constants of the sparse-set slot allocator.
`default_nettype none

package ssa_pkg;

    localparam int CAPACITY_DEF      = 1024;
    localparam int PAYLOAD_WIDTH_DEF = 64;
    localparam int ID_W              = 11;
    localparam int DATA_W            = 64;
    localparam int SLOT_OUT_W        = 10;
    localparam int STATUS_W          = 3;

    localparam logic REQ_ALLOC  = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_REUSED   = 3'd0,
        ST_NEW      = 3'd1,
        ST_FULL     = 3'd2,
        ST_REMOVED  = 3'd3,
        ST_INACTIVE = 3'd4,
        ST_BAD_ID   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RESOLVE,
        S_CHECK
    } state_t;

endpackage

`default_nettype wire

// File: rtl/ssa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ssa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/sparse_set_slot_allocator.sv
// Top level of the sparse-set slot allocator.
// After reset the block clears the id map and the slot store, one entry per
// cycle, with s_ready low. It then serves one request at a time: an allocate,
// a bad id or a full answer goes through S_IDLE (accept, free stack read) and
// S_RESOLVE (slot resolved), and a remove adds S_CHECK, because the slot
// read depends on the id map read. A finished result sits in the output
// register, so the next request is accepted while it waits; a request only
// stalls in its last cycle while an earlier result is still not taken.
`default_nettype none

module sparse_set_slot_allocator #(
    parameter int CAPACITY      = ssa_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_WIDTH = ssa_pkg::PAYLOAD_WIDTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_req_type,
    input  wire logic [ssa_pkg::ID_W-1:0]         s_entity_id,
    input  wire logic [ssa_pkg::DATA_W-1:0]       s_entry_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [ssa_pkg::STATUS_W-1:0]     m_status,
    output logic      [ssa_pkg::SLOT_OUT_W-1:0]   m_slot
);

    localparam int SW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int SLW = 1 + ssa_pkg::ID_W + PAYLOAD_WIDTH;
    localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);
    localparam logic [SW-1:0] LAST_SLOT = SW'(CAPACITY - 1);

    ssa_pkg::state_t  state_reg, state_next;
    logic [SW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0]    free_depth_reg, free_depth_next;
    logic [CW-1:0]    high_reg, high_next;
    logic             m_valid_reg, m_valid_next;
    ssa_pkg::status_t m_status_reg, m_status_next;
    logic [ssa_pkg::SLOT_OUT_W-1:0] m_slot_reg, m_slot_next;

    logic                      req_type_reg, req_type_next;
    logic [ssa_pkg::ID_W-1:0]  id_reg, id_next;
    logic [PAYLOAD_WIDTH-1:0]  data_reg, data_next;
    logic                      bad_reg, bad_next;
    logic [SW-1:0]             map_addr_reg, map_addr_next;

    logic           map_we, map_re;
    logic [SW-1:0]  map_wa, map_ra, map_wd, map_rd;
    logic           slot_we, slot_re;
    logic [SW-1:0]  slot_wa, slot_ra;
    logic [SLW-1:0] slot_wd, slot_rd;
    logic           stack_we, stack_re;
    logic [SW-1:0]  stack_wa, stack_ra, stack_wd, stack_rd;
    logic           out_free;
    logic [SW-1:0]  alloc_slot;

    ssa_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_id_map (
        .clk(aclk), .wr_en(map_we), .wr_addr(map_wa), .wr_data(map_wd),
        .rd_en(map_re), .rd_addr(map_ra), .rd_data(map_rd)
    );

    ssa_ram #(.WIDTH(SLW), .DEPTH(CAPACITY)) u_slot_store (
        .clk(aclk), .wr_en(slot_we), .wr_addr(slot_wa), .wr_data(slot_wd),
        .rd_en(slot_re), .rd_addr(slot_ra), .rd_data(slot_rd)
    );

    ssa_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_free_stack (
        .clk(aclk), .wr_en(stack_we), .wr_addr(stack_wa), .wr_data(stack_wd),
        .rd_en(stack_re), .rd_addr(stack_ra), .rd_data(stack_rd)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        free_depth_next = free_depth_reg;
        high_next       = high_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_slot_next     = m_slot_reg;
        req_type_next   = req_type_reg;
        id_next         = id_reg;
        data_next       = data_reg;
        bad_next        = bad_reg;
        map_addr_next   = map_addr_reg;
        s_ready         = 1'b0;
        map_we          = 1'b0;
        map_wa          = map_addr_reg;
        map_wd          = '0;
        map_re          = 1'b0;
        map_ra          = SW'(32'(s_entity_id) - 32'd1);
        slot_we         = 1'b0;
        slot_wa         = map_rd;
        slot_wd         = '0;
        slot_re         = 1'b0;
        slot_ra         = map_rd;
        stack_we        = 1'b0;
        stack_wa        = SW'(free_depth_reg);
        stack_wd        = map_rd;
        stack_re        = 1'b0;
        stack_ra        = SW'(free_depth_reg - 1'b1);
        alloc_slot      = stack_rd;

        case (state_reg)
            ssa_pkg::S_CLEAR: begin
                map_we       = 1'b1;
                map_wa       = clr_cnt_reg;
                slot_we      = 1'b1;
                slot_wa      = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_SLOT) begin
                    state_next = ssa_pkg::S_IDLE;
                end
            end
            ssa_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    map_re        = 1'b1;
                    stack_re      = 1'b1;
                    req_type_next = s_req_type;
                    id_next       = s_entity_id;
                    data_next     = s_entry_data[PAYLOAD_WIDTH-1:0];
                    bad_next      = (s_entity_id == '0) || (32'(s_entity_id) > CAPACITY);
                    map_addr_next = map_ra;
                    state_next    = ssa_pkg::S_RESOLVE;
                end
            end
            ssa_pkg::S_RESOLVE: begin
                if (bad_reg) begin
                    if (out_free) begin
                        m_valid_next  = 1'b1;
                        m_status_next = ssa_pkg::ST_BAD_ID;
                        m_slot_next   = '0;
                        state_next    = ssa_pkg::S_IDLE;
                    end
                end else if (req_type_reg == ssa_pkg::REQ_ALLOC) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        state_next   = ssa_pkg::S_IDLE;
                        if (free_depth_reg != '0) begin
                            alloc_slot      = stack_rd;
                            free_depth_next = free_depth_reg - 1'b1;
                            m_status_next   = ssa_pkg::ST_REUSED;
                        end else begin
                            alloc_slot    = SW'(high_reg);
                            m_status_next = ssa_pkg::ST_NEW;
                        end
                        if (free_depth_reg == '0 && high_reg == CAP_CNT) begin
                            m_status_next = ssa_pkg::ST_FULL;
                            m_slot_next   = '0;
                        end else begin
                            if (free_depth_reg == '0) begin
                                high_next = high_reg + 1'b1;
                            end
                            slot_we     = 1'b1;
                            slot_wa     = alloc_slot;
                            slot_wd     = {1'b1, id_reg, data_reg};
                            map_we      = 1'b1;
                            map_wa      = map_addr_reg;
                            map_wd      = alloc_slot;
                            m_slot_next = ssa_pkg::SLOT_OUT_W'(alloc_slot);
                        end
                    end
                end else begin
                    slot_re    = 1'b1;
                    slot_ra    = map_rd;
                    state_next = ssa_pkg::S_CHECK;
                end
            end
            ssa_pkg::S_CHECK: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ssa_pkg::S_IDLE;
                    if (slot_rd[SLW-1]) begin
                        slot_we       = 1'b1;
                        slot_wa       = map_rd;
                        slot_wd       = {1'b0, slot_rd[SLW-2:0]};
                        m_status_next = ssa_pkg::ST_REMOVED;
                        m_slot_next   = ssa_pkg::SLOT_OUT_W'(map_rd);
                        if (free_depth_reg < CAP_CNT) begin
                            stack_we        = 1'b1;
                            stack_wa        = SW'(free_depth_reg);
                            stack_wd        = map_rd;
                            free_depth_next = free_depth_reg + 1'b1;
                        end
                    end else begin
                        m_status_next = ssa_pkg::ST_INACTIVE;
                        m_slot_next   = '0;
                    end
                end
            end
            default: begin
                state_next = ssa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ssa_pkg::S_CLEAR;
            clr_cnt_reg    <= '0;
            free_depth_reg <= '0;
            high_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            free_depth_reg <= free_depth_next;
            high_reg       <= high_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_slot_reg   <= m_slot_next;
        req_type_reg <= req_type_next;
        id_reg       <= id_next;
        data_reg     <= data_next;
        bad_reg      <= bad_next;
        map_addr_reg <= map_addr_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_slot   = m_slot_reg;

endmodule

`default_nettype wire

// File: rtl/ssa_checker.sv
// Port-level checker of the sparse-set slot allocator and its bind.
`default_nettype none
`include "assert_macros.svh"

module ssa_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_valid,
    input wire logic                           s_ready,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire logic [ssa_pkg::STATUS_W-1:0]   m_status,
    input wire logic [ssa_pkg::SLOT_OUT_W-1:0] m_slot
);

    logic no_slot_status;
    logic known_status;

    assign no_slot_status = (m_status == ssa_pkg::ST_FULL) ||
                            (m_status == ssa_pkg::ST_INACTIVE) ||
                            (m_status == ssa_pkg::ST_BAD_ID);
    assign known_status   = (m_status <= ssa_pkg::ST_BAD_ID);

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_status) && $stable(m_slot), "Result beat changed while stalled.")
    `ASSERT_SAME(a_no_slot, aclk, aresetn, m_valid && no_slot_status,
        m_slot == '0, "Failed request reports a nonzero slot.")
    `ASSERT_SAME(a_status_code, aclk, aresetn, m_valid,
        known_status, "Result beat carries an unknown status code.")
    `ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready,
        !s_ready, "Input beat accepted in back-to-back cycles.")

endmodule

bind sparse_set_slot_allocator ssa_checker u_ssa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_status (m_status),
    .m_slot   (m_slot)
);

`default_nettype wire

// File: tb/sv/tb.sv
// Testbench for the sparse-set slot allocator: directed and random requests checked by a predictor.
`timescale 1ns / 100ps

module tb;

    localparam int CAP            = ssa_pkg::CAPACITY_DEF;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        ssa_pkg::status_t                 status;
        logic [ssa_pkg::SLOT_OUT_W-1:0]   slot;
    } answer_t;

    class slot_pool_tracker;
        logic [ssa_pkg::SLOT_OUT_W-1:0] id_map [CAP];
        bit                             slot_busy [CAP];
        logic [ssa_pkg::SLOT_OUT_W-1:0] free_slots [CAP];
        int                             free_count;
        int                             high_mark;
        answer_t                        expected_answers [$];
        int                             mismatches;
        int                             answers_checked;

        function new();
            foreach (id_map[i]) begin
                id_map[i]     = '0;
                slot_busy[i]  = 1'b0;
                free_slots[i] = '0;
            end
            free_count      = 0;
            high_mark       = 0;
            mismatches      = 0;
            answers_checked = 0;
        endfunction

        function void note_request(logic req, logic [ssa_pkg::ID_W-1:0] id);
            answer_t a;
            int      slot;
            a.slot = '0;
            slot   = -1;
            if (id == 0 || id > CAP) begin
                a.status = ssa_pkg::ST_BAD_ID;
            end else if (req == ssa_pkg::REQ_ALLOC) begin
                if (free_count > 0) begin
                    free_count--;
                    slot     = free_slots[free_count];
                    a.status = ssa_pkg::ST_REUSED;
                end else if (high_mark < CAP) begin
                    slot     = high_mark;
                    high_mark++;
                    a.status = ssa_pkg::ST_NEW;
                end else begin
                    a.status = ssa_pkg::ST_FULL;
                end
                if (slot >= 0) begin
                    slot_busy[slot] = 1'b1;
                    id_map[id - 1]  = slot[ssa_pkg::SLOT_OUT_W-1:0];
                    a.slot          = slot[ssa_pkg::SLOT_OUT_W-1:0];
                end
            end else begin
                slot = id_map[id - 1];
                if (!slot_busy[slot]) begin
                    a.status = ssa_pkg::ST_INACTIVE;
                end else begin
                    slot_busy[slot]        = 1'b0;
                    free_slots[free_count] = slot[ssa_pkg::SLOT_OUT_W-1:0];
                    free_count++;
                    a.status = ssa_pkg::ST_REMOVED;
                    a.slot   = slot[ssa_pkg::SLOT_OUT_W-1:0];
                end
            end
            expected_answers.push_back(a);
        endfunction

        function void check_answer(logic [ssa_pkg::STATUS_W-1:0] status,
                                   logic [ssa_pkg::SLOT_OUT_W-1:0] slot);
            answer_t want;
            answers_checked++;
            if (expected_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected result status %0d slot %0d", status, slot);
            end else begin
                want = expected_answers.pop_front();
                if (status !== want.status || slot !== want.slot) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: mismatch expected status %0d slot %0d, got status %0d slot %0d",
                                 want.status, want.slot, status, slot);
                end
            end
        endfunction

        function int pending();
            return expected_answers.size();
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic                           s_req_type;
    logic [ssa_pkg::ID_W-1:0]       s_entity_id;
    logic [ssa_pkg::DATA_W-1:0]     s_entry_data;
    logic                           m_valid;
    logic                           m_ready;
    logic [ssa_pkg::STATUS_W-1:0]   m_status;
    logic [ssa_pkg::SLOT_OUT_W-1:0] m_slot;

    slot_pool_tracker pool;
    int               idle_cycles;

    sparse_set_slot_allocator dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_entity_id  (s_entity_id),
        .s_entry_data (s_entry_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_slot       (m_slot)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    task automatic send_request(input logic req, input logic [ssa_pkg::ID_W-1:0] id,
                                input logic [ssa_pkg::DATA_W-1:0] data);
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_entity_id  <= id;
        s_entry_data <= data;
        do @(posedge aclk); while (!s_ready);
        pool.note_request(req, id);
    endtask

    task automatic pause_sender(input int gap);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    function automatic int random_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    endfunction

    function automatic logic [ssa_pkg::DATA_W-1:0] random_payload();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [ssa_pkg::ID_W-1:0] pick_id(input int span);
        int dice;
        dice = $urandom_range(0, 99);
        if (dice < 3)
            return '0;
        else if (dice < 7)
            return ssa_pkg::ID_W'($urandom_range(CAP + 1, (1 << ssa_pkg::ID_W) - 1));
        else if (dice < 14)
            return ssa_pkg::ID_W'($urandom_range(1, CAP));
        return ssa_pkg::ID_W'($urandom_range(1, span));
    endfunction

    task automatic run_random(input int count, input int span, input int alloc_pct);
        int   left;
        int   burst;
        logic req;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && left > 0) begin
                req = ($urandom_range(0, 99) < alloc_pct) ? ssa_pkg::REQ_ALLOC
                                                          : ssa_pkg::REQ_REMOVE;
                send_request(req, pick_id(span), random_payload());
                burst--;
                left--;
            end
            pause_sender(random_gap());
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            pool.check_answer(m_status, m_slot);
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : result_sink
        int mode;
        int span;
        bit held;
        m_ready = 1'b0;
        held    = 1'b0;
        @(posedge aresetn);
        forever begin
            if (!held && pool.answers_checked >= 120) begin
                held = 1'b1;
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (399) @(negedge aclk);
            end
            mode = $urandom_range(0, 2);
            span = $urandom_range(8, 64);
            repeat (span) begin
                @(negedge aclk);
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        pool         = new();
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_req_type   = ssa_pkg::REQ_ALLOC;
        s_entity_id  = '0;
        s_entry_data = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Removes before any allocate, bad ids, remapping and stale ids.
        send_request(ssa_pkg::REQ_REMOVE, 11'd1,    '0);
        send_request(ssa_pkg::REQ_ALLOC,  11'd0,    '1);
        send_request(ssa_pkg::REQ_REMOVE, 11'd0,    '0);
        send_request(ssa_pkg::REQ_ALLOC,  11'd2047, '1);
        send_request(ssa_pkg::REQ_REMOVE, 11'd1025, '1);
        send_request(ssa_pkg::REQ_ALLOC,  11'd1,    '0);
        send_request(ssa_pkg::REQ_ALLOC,  11'd1024, '1);
        send_request(ssa_pkg::REQ_ALLOC,  11'd1,    64'h5555_5555_5555_5555);
        send_request(ssa_pkg::REQ_REMOVE, 11'd1,    '0);
        send_request(ssa_pkg::REQ_REMOVE, 11'd1,    '0);
        pause_sender(3);
        send_request(ssa_pkg::REQ_REMOVE, 11'd5,    '0);
        send_request(ssa_pkg::REQ_ALLOC,  11'd7,    64'h0123_4567_89ab_cdef);
        send_request(ssa_pkg::REQ_ALLOC,  11'd8,    64'hfedc_ba98_7654_3210);
        send_request(ssa_pkg::REQ_REMOVE, 11'd1,    '0);
        send_request(ssa_pkg::REQ_REMOVE, 11'd1024, '1);
        send_request(ssa_pkg::REQ_ALLOC,  11'd1024, '1);
        send_request(ssa_pkg::REQ_ALLOC,  11'd512,  64'haaaa_aaaa_aaaa_aaaa);
        send_request(ssa_pkg::REQ_REMOVE, 11'd7,    '0);
        send_request(ssa_pkg::REQ_ALLOC,  11'd3,    '0);
        send_request(ssa_pkg::REQ_ALLOC,  11'd4,    '1);
        pause_sender(5);

        run_random(200, 24, 55);
        run_random(220, CAP, 45);
        run_random(60, 16, 50);

        pause_sender(1);
        while (pool.pending() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (pool.mismatches == 0 && pool.pending() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
